// ----- hdl/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with search.
package bdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 5;

  localparam logic [WORD_W-1:0] NONE_WORD = '1;

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_POP_FRONT  = 2'd1,
    ACT_PUSH_FRONT = 2'd2,
    ACT_SEARCH     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REPORT
  } state_t;

  // What every cell of the chain does in the coming cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [WORD_W-1:0]  data;
  } cell_cmd_t;

endpackage

// ----- hdl/bdq_cell.sv -----
// One storage cell of the deque chain; it shifts with its neighbors or loads a word.
module bdq_cell (
  input  logic                      clk,
  input  bdq_pkg::cell_cmd_t        cmd,
  input  logic                      hit,
  input  logic [bdq_pkg::WORD_W-1:0] left_in,
  input  logic [bdq_pkg::WORD_W-1:0] right_in,
  output logic [bdq_pkg::WORD_W-1:0] q
);

  logic [bdq_pkg::WORD_W-1:0] data_r;
  logic [bdq_pkg::WORD_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      bdq_pkg::CELL_HOLD: data_nxt = data_r;
      bdq_pkg::CELL_SHL:  data_nxt = right_in;
      bdq_pkg::CELL_SHR:  data_nxt = left_in;
      bdq_pkg::CELL_LOAD: begin
        if (hit) begin
          data_nxt = cmd.data;
        end
      end
      default:            data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ----- hdl/bdq_ctrl.sv -----
// Request sequencer, occupancy count and result register of the deque.
module bdq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_value,
  input  logic [bdq_pkg::WORD_W-1:0]        head_word,
  output bdq_pkg::cell_cmd_t                cmd,
  output logic [$clog2(DEPTH+1)-1:0]        load_idx,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bdq_pkg::WORD_W-1:0] out_popped_value,
  output logic                              out_found,
  output logic [1:0]                        out_status,
  output logic [bdq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bdq_pkg::state_t  state_r, state_nxt;
  bdq_pkg::action_t action;

  logic [CW-1:0]                count_r, count_nxt;
  logic [SW-1:0]                step_r, step_nxt;
  logic                         found_r, found_nxt;
  logic [bdq_pkg::WORD_W-1:0]   key_r, key_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bdq_pkg::WORD_W-1:0]   popped_r, popped_nxt;
  logic                         found_out_r, found_out_nxt;
  bdq_pkg::status_t             status_r, status_nxt;
  logic [CW-1:0]                occ_r, occ_nxt;

  logic accept;
  logic out_free;
  logic full;
  logic empty;
  logic last_step;
  logic load_result;

  assign action    = bdq_pkg::action_t'(in_action);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == bdq_pkg::ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign last_step = (step_r == SW'(DEPTH - 1));
  assign load_idx  = count_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (accept && action == bdq_pkg::ACT_SEARCH) begin
          state_nxt = bdq_pkg::ST_SEARCH;
        end
      end
      bdq_pkg::ST_SEARCH: begin
        if (last_step) begin
          state_nxt = bdq_pkg::ST_REPORT;
        end
      end
      bdq_pkg::ST_REPORT: begin
        if (out_free) begin
          state_nxt = bdq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bdq_pkg::ST_IDLE;
    endcase
  end

  // Chain commands, counters and result.
  always_comb begin
    cmd.op        = bdq_pkg::CELL_HOLD;
    cmd.data      = in_value;
    count_nxt     = count_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    load_result   = 1'b0;
    popped_nxt    = bdq_pkg::NONE_WORD;
    found_out_nxt = 1'b0;
    status_nxt    = bdq_pkg::STAT_OK;
    occ_nxt       = count_r;

    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (action)
            bdq_pkg::ACT_PUSH_BACK: begin
              load_result = 1'b1;
              if (full) begin
                status_nxt = bdq_pkg::STAT_FULL;
              end else begin
                cmd.op    = bdq_pkg::CELL_LOAD;
                count_nxt = count_r + CW'(1);
                occ_nxt   = count_nxt;
              end
            end
            bdq_pkg::ACT_POP_FRONT: begin
              load_result = 1'b1;
              if (empty) begin
                status_nxt = bdq_pkg::STAT_EMPTY;
              end else begin
                cmd.op     = bdq_pkg::CELL_SHL;
                popped_nxt = head_word;
                count_nxt  = count_r - CW'(1);
                occ_nxt    = count_nxt;
              end
            end
            bdq_pkg::ACT_PUSH_FRONT: begin
              load_result = 1'b1;
              if (full) begin
                status_nxt = bdq_pkg::STAT_FULL;
              end else begin
                cmd.op    = bdq_pkg::CELL_SHR;
                count_nxt = count_r + CW'(1);
                occ_nxt   = count_nxt;
              end
            end
            bdq_pkg::ACT_SEARCH: begin
              key_nxt   = in_value;
              step_nxt  = '0;
              found_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      bdq_pkg::ST_SEARCH: begin
        // The whole chain rotates once; the head cell sees every held word in order.
        cmd.op = bdq_pkg::CELL_SHL;
        if (head_word == key_r && CW'(step_r) < count_r) begin
          found_nxt = 1'b1;
        end
        step_nxt = step_r + SW'(1);
      end
      bdq_pkg::ST_REPORT: begin
        load_result   = out_free;
        found_out_nxt = found_r;
      end
      default: ;
    endcase

    if (load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    found_r <= found_nxt;
    key_r   <= key_nxt;
    if (load_result) begin
      popped_r    <= popped_nxt;
      found_out_r <= found_out_nxt;
      status_r    <= status_nxt;
      occ_r       <= occ_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_found        = found_out_r;
  assign out_status       = status_r;
  assign out_occupancy    = bdq_pkg::OCC_W'(occ_r);

endmodule

// ----- hdl/bounded_deque_with_search.sv -----
// Top level of the bounded deque: sequencer plus a chain of storage cells.
//
// Each input request carries an action (push back, pop front, push front,
// search) and a 32-bit signed word; each request yields exactly one result
// with the popped word (-1 unless a pop succeeds), a found flag, a status
// (ok, pop on empty, insert dropped because full) and the occupancy after it.
// The words live in a row of DEPTH cells with the front word always in cell 0.
// Push front and pop shift the whole row by one place; push back loads the
// cell at the current count. The result of these is in the output register
// after the accepting edge, and the sequencer stays idle, so a new request
// can be taken as soon as the result register is free. Search rotates the
// row once while cell 0 is compared with the key, then enters its report
// state, which loads the result register; the next request is taken once
// the sequencer is back in idle.
// Both channels use valid/ready. While the result register is full and the
// receiver stalls, no new request is accepted; a finished search waits in
// its report state until the register is free.
// Reset (rst_n low, synchronous) empties the queue; stored words are not
// cleared and are never read before they are written.
module bounded_deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bdq_pkg::WORD_W-1:0] out_popped_value,
  output logic                              out_found,
  output logic [1:0]                        out_status,
  output logic [bdq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  bdq_pkg::cell_cmd_t          cmd;
  logic [CW-1:0]               load_idx;
  logic [bdq_pkg::WORD_W-1:0]  cell_q [DEPTH];

  bdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_value         (in_value),
    .head_word        (cell_q[0]),
    .cmd              (cmd),
    .load_idx         (load_idx),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_found        (out_found),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [bdq_pkg::WORD_W-1:0] left_in;
    logic [bdq_pkg::WORD_W-1:0] right_in;
    logic                       hit;

    // The head cell takes a pushed-front word; the tail closes the ring.
    if (i == 0) begin : g_head
      assign left_in = cmd.data;
    end else begin : g_body
      assign left_in = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_in = cell_q[0];
    end else begin : g_mid
      assign right_in = cell_q[i+1];
    end

    assign hit = (load_idx == CW'(i));

    bdq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .hit      (hit),
      .left_in  (left_in),
      .right_in (right_in),
      .q        (cell_q[i])
    );
  end

endmodule
